/* hdl/pseudo_inverse_2x2_defines.svh */
// assertion macros used by the pseudo-inverse rtl
`ifndef PSEUDO_INVERSE_2X2_DEFINES_SVH
`define PSEUDO_INVERSE_2X2_DEFINES_SVH

// condition in a cycle implies a check in the same cycle
`define PI_ASSERT_IMPL(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("pseudo_inverse_2x2 check failed");

// condition in a cycle implies a check in the next cycle
`define PI_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("pseudo_inverse_2x2 check failed");

`endif

/* hdl/pinv_pkg.sv */
// types, constants and the arctangent table of the pseudo-inverse pipeline
`default_nettype none

package pinv_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int XW = 36;
	localparam int ZW = 36;
	localparam int MAGW = 34;
	localparam int SW = 35;
	localparam int DMW = 34;
	localparam int DRW = 35;
	localparam int DQW = 41;
	localparam int IW = 42;
	localparam int TW = 22;
	localparam int VW = 44;
	localparam int SH = 20;
	localparam int RECIP_SHIFT = 43;
	localparam int DIV_STEPS = DQW;
	localparam int DIV_REM0 = 2 ** (RECIP_SHIFT - DQW);
	localparam int CLAMP_MAG = 2 ** (RECIP_SHIFT - (DQW - 1));

	localparam logic [15:0] EPS_RESET = 16'd410;
	localparam logic signed [ZW-1:0] ANG_PI = 36'sd3373259426;
	localparam logic signed [ZW-1:0] ANG_HALF_PI = 36'sd1686629713;
	localparam logic signed [XW-1:0] GAIN_INV = 36'sd652032874;
	localparam logic signed [IW-1:0] RECIP_LIM = 42'sh100_0000_0000;
	localparam logic signed [31:0] OUT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] OUT_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [15:0] a_r0c0;
		logic signed [15:0] a_r0c1;
		logic signed [15:0] a_r1c0;
		logic signed [15:0] a_r1c1;
	} mat_t;

	typedef struct packed {
		logic signed [31:0] p_r0c0;
		logic signed [31:0] p_r0c1;
		logic signed [31:0] p_r1c0;
		logic signed [31:0] p_r1c1;
	} pinv_t;

	typedef struct packed {
		logic zero;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} vec_lane_t;

	typedef struct packed {
		logic valid;
		vec_lane_t eh;
		vec_lane_t fg;
	} vec_beat_t;

	typedef struct packed {
		logic neg;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} rot_lane_t;

	typedef struct packed {
		logic valid;
		rot_lane_t b;
		rot_lane_t t;
		logic signed [SW-1:0] s0;
		logic signed [SW-1:0] s1;
	} rot_beat_t;

	typedef struct packed {
		logic neg;
		logic zero;
		logic clamp;
		logic [DMW-1:0] m;
		logic [DRW-1:0] r;
		logic [DQW-1:0] q;
	} div_lane_t;

	typedef struct packed {
		logic valid;
		div_lane_t d0;
		div_lane_t d1;
		logic signed [TW-1:0] cb;
		logic signed [TW-1:0] sb;
		logic signed [TW-1:0] ct;
		logic signed [TW-1:0] st;
	} div_beat_t;

	// arctangent of 2^-idx in radians, q.30, truncated
	function automatic logic signed [ZW-1:0] atan_q30(input int idx);
		logic signed [ZW-1:0] r;
		unique case (idx)
			0: r = ZW'(32'h3243F6A8);
			1: r = ZW'(32'h1DAC6705);
			2: r = ZW'(32'h0FADBAFC);
			3: r = ZW'(32'h07F56EA6);
			4: r = ZW'(32'h03FEAB76);
			5: r = ZW'(32'h01FFD55B);
			6: r = ZW'(32'h00FFFAAA);
			7: r = ZW'(32'h007FFF55);
			8: r = ZW'(32'h003FFFEA);
			9: r = ZW'(32'h001FFFFD);
			10: r = ZW'(32'h000FFFFF);
			11: r = ZW'(32'h0007FFFF);
			12: r = ZW'(32'h0003FFFF);
			13: r = ZW'(32'h0001FFFF);
			14: r = ZW'(32'h0000FFFF);
			15: r = ZW'(32'h00007FFF);
			16: r = ZW'(32'h00003FFF);
			17: r = ZW'(32'h00001FFF);
			18: r = ZW'(32'h00000FFF);
			19: r = ZW'(32'h000007FF);
			20: r = ZW'(32'h000003FF);
			21: r = ZW'(32'h000001FF);
			22: r = ZW'(32'h000000FF);
			23: r = ZW'(32'h0000007F);
			24: r = ZW'(32'h0000003F);
			25: r = ZW'(32'h0000001F);
			26: r = ZW'(32'h0000000F);
			27: r = ZW'(32'h00000008);
			28: r = ZW'(32'h00000004);
			29: r = ZW'(32'h00000002);
			30: r = ZW'(32'h00000001);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* hdl/pinv_vec_cell.sv */
// one vectoring cordic stage for both half-sum vectors
`default_nettype none

module pinv_vec_cell import pinv_pkg::*; #(
	parameter int STAGE = 0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire vec_beat_t d,
	output vec_beat_t nxt
);

	logic valid_q;
	vec_lane_t eh_q;
	vec_lane_t fg_q;

	function automatic vec_lane_t vstep(input vec_lane_t l);
		vec_lane_t o;
		logic signed [XW-1:0] dx;
		logic signed [XW-1:0] dy;
		dx = l.y >>> STAGE;
		dy = l.x >>> STAGE;
		o = l;
		if (l.y > 0) begin
			o.x = l.x + dx;
			o.y = l.y - dy;
			o.z = l.z + atan_q30(STAGE);
		end else begin
			o.x = l.x - dx;
			o.y = l.y + dy;
			o.z = l.z - atan_q30(STAGE);
		end
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eh_q <= vstep(d.eh);
			fg_q <= vstep(d.fg);
		end
	end

	assign nxt = '{valid: valid_q, eh: eh_q, fg: fg_q};

endmodule

`default_nettype wire

/* hdl/pinv_rot_cell.sv */
// one rotation cordic stage for both half angles
`default_nettype none

module pinv_rot_cell import pinv_pkg::*; #(
	parameter int STAGE = 0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire rot_beat_t d,
	output rot_beat_t nxt
);

	logic valid_q;
	rot_lane_t b_q;
	rot_lane_t t_q;
	logic signed [SW-1:0] s0_q;
	logic signed [SW-1:0] s1_q;

	function automatic rot_lane_t rstep(input rot_lane_t l);
		rot_lane_t o;
		logic signed [XW-1:0] dx;
		logic signed [XW-1:0] dy;
		dx = l.y >>> STAGE;
		dy = l.x >>> STAGE;
		o = l;
		if (l.z >= 0) begin
			o.x = l.x - dx;
			o.y = l.y + dy;
			o.z = l.z - atan_q30(STAGE);
		end else begin
			o.x = l.x + dx;
			o.y = l.y - dy;
			o.z = l.z + atan_q30(STAGE);
		end
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_q <= rstep(d.b);
			t_q <= rstep(d.t);
			s0_q <= d.s0;
			s1_q <= d.s1;
		end
	end

	assign nxt = '{valid: valid_q, b: b_q, t: t_q, s0: s0_q, s1: s1_q};

endmodule

`default_nettype wire

/* hdl/pinv_div_cell.sv */
// one restoring division step of both reciprocals, one quotient bit each
`default_nettype none

module pinv_div_cell import pinv_pkg::*; #(
	parameter int STAGE = 0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire div_beat_t d,
	output div_beat_t nxt
);

	localparam int QBIT = DQW - 1 - STAGE;

	logic valid_q;
	div_lane_t d0_q;
	div_lane_t d1_q;
	logic signed [TW-1:0] cb_q;
	logic signed [TW-1:0] sb_q;
	logic signed [TW-1:0] ct_q;
	logic signed [TW-1:0] st_q;

	// dividend bits below the top are all zero
	function automatic div_lane_t dstep(input div_lane_t l);
		div_lane_t o;
		logic [DRW-1:0] r2;
		o = l;
		r2 = {l.r[DRW-2:0], 1'b0};
		if (r2 >= {1'b0, l.m}) begin
			r2 = r2 - {1'b0, l.m};
			o.q[QBIT] = 1'b1;
		end
		o.r = r2;
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d0_q <= dstep(d.d0);
			d1_q <= dstep(d.d1);
			cb_q <= d.cb;
			sb_q <= d.sb;
			ct_q <= d.ct;
			st_q <= d.st;
		end
	end

	assign nxt = '{valid: valid_q, d0: d0_q, d1: d1_q, cb: cb_q, sb: sb_q, ct: ct_q, st: st_q};

endmodule

`default_nettype wire

/* hdl/pseudo_inverse_2x2.sv */
// Pseudo-inverse of a 2x2 matrix through a closed-form SVD, fully pipelined.
//
// Input channel mat (mat_valid, mat_stall, mat): one matrix a beat, four signed
// Q4.12 elements. Output channel pinv (pinv_valid, pinv_stall, pinv): four
// saturated signed Q16.16 elements, row-major. A beat moves when valid is high
// and stall is low. The cfg channel (cfg_valid, cfg_ready, cfg_data) writes the
// singular value threshold; cfg_ready is always high.
// Throughput: one matrix per cycle while pinv is not stalled. The latency from
// accepting a matrix to its result showing on pinv is set by the two cordic
// cell rows, the 41-step reciprocal divider row and the other stage registers.
// When pinv is stalled with a result waiting, the whole pipeline holds and
// mat_stall rises in the same cycle; empty slots hold in place as well.
// Reset clears all stage valids and sets the threshold to 410 (about 0.1).
`default_nettype none
`include "pseudo_inverse_2x2_defines.svh"

module pseudo_inverse_2x2 import pinv_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic mat_valid,
	output logic mat_stall,
	input wire mat_t mat,
	output logic pinv_valid,
	input wire logic pinv_stall,
	output pinv_t pinv,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [15:0] cfg_data
);

	localparam int TXW = TW + 1;
	localparam int IHW = IW - SH;
	localparam int PHW = IHW + TXW;
	localparam int PLW = SH + 1 + TXW;
	localparam int VHW = VW - SH;
	localparam int PAH = VHW + TW;
	localparam int PAL = SH + 1 + TW;
	localparam int HIW = PAH + 1;
	localparam int LOW = PAL + 1;
	localparam int RESW = HIW + 1;

	logic en;
	logic [15:0] eps_q;

	// stage registers
	logic valid_s1;
	vec_lane_t eh_s1, fg_s1;
	logic valid_s2;
	logic signed [MAGW-1:0] q_s2, r_s2;
	logic signed [ZW-1:0] b_s2, t_s2;
	logic valid_s3;
	rot_lane_t b_s3, t_s3;
	logic signed [SW-1:0] sv0_s3, sv1_s3;
	logic valid_s4;
	div_lane_t d0_s4, d1_s4;
	logic signed [TW-1:0] cb_s4, sb_s4, ct_s4, st_s4;
	logic valid_s5;
	logic signed [IW-1:0] i0_s5, i1_s5;
	logic signed [TW-1:0] cb_s5, sb_s5, ct_s5, st_s5;
	logic valid_s6;
	logic signed [PHW-1:0] ph_s6 [4];
	logic signed [PLW-SH-1:0] pl_s6 [4];
	logic signed [TW-1:0] cb_s6, sb_s6;
	logic valid_s7;
	logic signed [VW-1:0] v_s7 [4];
	logic signed [TW-1:0] cb_s7, sb_s7;
	logic valid_s8;
	logic signed [PAH-1:0] pah_s8 [4], pbh_s8 [4];
	logic signed [PAL-1:0] pal_s8 [4], pbl_s8 [4];
	logic valid_s9;
	logic signed [RESW-1:0] res_s9 [4];
	logic out_valid_q;
	pinv_t out_q;

	vec_beat_t vec_head;
	vec_beat_t vchain [CORDIC_STAGES];
	rot_beat_t rot_head;
	rot_beat_t rchain [CORDIC_STAGES];
	div_beat_t div_head;
	div_beat_t dchain [DIV_STEPS];

	// the whole pipeline moves unless a finished result is held up
	assign en = !out_valid_q || !pinv_stall;
	assign mat_stall = !en;
	assign pinv_valid = out_valid_q;
	assign pinv = out_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			eps_q <= cfg_data;
		end
	end

	// ---- helpers ----
	function automatic vec_lane_t vec_init(input logic signed [16:0] sx,
			input logic signed [16:0] sy);
		vec_lane_t o;
		logic signed [XW-1:0] xe;
		logic signed [XW-1:0] ye;
		xe = XW'(sx) <<< 14;
		ye = XW'(sy) <<< 14;
		o.zero = (sx == '0) && (sy == '0);
		if (xe < 0) begin
			o.x = -xe;
			o.y = -ye;
			o.z = (ye >= 0) ? ANG_PI : -ANG_PI;
		end else begin
			o.x = xe;
			o.y = ye;
			o.z = '0;
		end
		return o;
	endfunction

	function automatic logic signed [MAGW-1:0] mag_of(input vec_lane_t l);
		logic [61:0] pr;
		pr = l.x[31:0] * GAIN_INV[29:0];
		return l.zero ? '0 : MAGW'(pr[61:30]);
	endfunction

	function automatic rot_lane_t rot_init(input logic signed [ZW-1:0] z);
		rot_lane_t o;
		o.x = GAIN_INV;
		o.y = '0;
		o.z = z;
		o.neg = 1'b0;
		if (z > ANG_HALF_PI) begin
			o.z = z - ANG_PI;
			o.neg = 1'b1;
		end else if (z < -ANG_HALF_PI) begin
			o.z = z + ANG_PI;
			o.neg = 1'b1;
		end
		return o;
	endfunction

	function automatic logic signed [TW-1:0] trig(input logic neg,
			input logic signed [XW-1:0] v);
		logic signed [XW-1:0] w;
		w = neg ? -v : v;
		w = w >>> 10;
		return w[TW-1:0];
	endfunction

	function automatic div_lane_t div_init(input logic signed [SW-1:0] s,
			input logic [15:0] eps);
		div_lane_t o;
		logic signed [SW-1:0] a;
		a = (s < 0) ? -s : s;
		o.m = DMW'(a);
		o.neg = s < 0;
		o.zero = (s == '0) || (o.m < DMW'({eps, 15'b0}));
		o.clamp = o.m < DMW'(CLAMP_MAG);
		o.r = DRW'(DIV_REM0);
		o.q = '0;
		return o;
	endfunction

	function automatic logic signed [IW-1:0] inv_of(input div_lane_t l);
		logic signed [IW-1:0] mg;
		mg = l.clamp ? RECIP_LIM : $signed(IW'(l.q));
		if (l.zero) begin
			return '0;
		end
		return l.neg ? -mg : mg;
	endfunction

	// ---- s1: half sums and differences, pre-rotation ----
	logic signed [16:0] sum_e, sum_f, sum_g, sum_h;
	assign sum_e = 17'(mat.a_r0c0) + 17'(mat.a_r1c1);
	assign sum_f = 17'(mat.a_r0c0) - 17'(mat.a_r1c1);
	assign sum_g = 17'(mat.a_r0c1) + 17'(mat.a_r1c0);
	assign sum_h = 17'(mat.a_r0c1) - 17'(mat.a_r1c0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1 <= mat_valid;
			valid_s2 <= vchain[CORDIC_STAGES-1].valid;
			valid_s3 <= valid_s2;
			valid_s4 <= rchain[CORDIC_STAGES-1].valid;
			valid_s5 <= dchain[DIV_STEPS-1].valid;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
			out_valid_q <= valid_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eh_s1 <= vec_init(sum_e, sum_h);
			fg_s1 <= vec_init(sum_f, sum_g);
		end
	end

	assign vec_head = '{valid: valid_s1, eh: eh_s1, fg: fg_s1};

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
		if (i == 0) begin : g_first
			pinv_vec_cell #(.STAGE(i)) u_cell (.clk(clk), .arst_n(arst_n), .en(en),
				.d(vec_head), .nxt(vchain[i]));
		end else begin : g_rest
			pinv_vec_cell #(.STAGE(i)) u_cell (.clk(clk), .arst_n(arst_n), .en(en),
				.d(vchain[i-1]), .nxt(vchain[i]));
		end
	end

	// ---- s2: magnitudes and half angles ----
	vec_beat_t vend;
	logic signed [ZW-1:0] ang_eh, ang_fg;
	logic signed [ZW:0] adiff, asum;
	assign vend = vchain[CORDIC_STAGES-1];
	assign ang_eh = vend.eh.zero ? '0 : vend.eh.z;
	assign ang_fg = vend.fg.zero ? '0 : vend.fg.z;
	assign adiff = (ZW+1)'(ang_eh) - (ZW+1)'(ang_fg);
	assign asum = (ZW+1)'(ang_eh) + (ZW+1)'(ang_fg);

	always_ff @(posedge clk) begin
		if (en) begin
			q_s2 <= mag_of(vend.eh);
			r_s2 <= mag_of(vend.fg);
			b_s2 <= adiff[ZW:1];
			t_s2 <= asum[ZW:1];
		end
	end

	// ---- s3: singular values, rotation start ----
	always_ff @(posedge clk) begin
		if (en) begin
			b_s3 <= rot_init(b_s2);
			t_s3 <= rot_init(t_s2);
			sv0_s3 <= SW'(q_s2) + SW'(r_s2);
			sv1_s3 <= SW'(q_s2) - SW'(r_s2);
		end
	end

	assign rot_head = '{valid: valid_s3, b: b_s3, t: t_s3, s0: sv0_s3, s1: sv1_s3};

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
		if (i == 0) begin : g_first
			pinv_rot_cell #(.STAGE(i)) u_cell (.clk(clk), .arst_n(arst_n), .en(en),
				.d(rot_head), .nxt(rchain[i]));
		end else begin : g_rest
			pinv_rot_cell #(.STAGE(i)) u_cell (.clk(clk), .arst_n(arst_n), .en(en),
				.d(rchain[i-1]), .nxt(rchain[i]));
		end
	end

	// ---- s4: cos and sin, divider start ----
	rot_beat_t rend;
	assign rend = rchain[CORDIC_STAGES-1];

	always_ff @(posedge clk) begin
		if (en) begin
			cb_s4 <= trig(rend.b.neg, rend.b.x);
			sb_s4 <= trig(rend.b.neg, rend.b.y);
			ct_s4 <= trig(rend.t.neg, rend.t.x);
			st_s4 <= trig(rend.t.neg, rend.t.y);
			d0_s4 <= div_init(rend.s0, eps_q);
			d1_s4 <= div_init(rend.s1, eps_q);
		end
	end

	assign div_head = '{valid: valid_s4, d0: d0_s4, d1: d1_s4,
		cb: cb_s4, sb: sb_s4, ct: ct_s4, st: st_s4};

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		if (i == 0) begin : g_first
			pinv_div_cell #(.STAGE(i)) u_cell (.clk(clk), .arst_n(arst_n), .en(en),
				.d(div_head), .nxt(dchain[i]));
		end else begin : g_rest
			pinv_div_cell #(.STAGE(i)) u_cell (.clk(clk), .arst_n(arst_n), .en(en),
				.d(dchain[i-1]), .nxt(dchain[i]));
		end
	end

	// ---- s5: signed, clamped reciprocals ----
	div_beat_t dend;
	assign dend = dchain[DIV_STEPS-1];

	always_ff @(posedge clk) begin
		if (en) begin
			i0_s5 <= inv_of(dend.d0);
			i1_s5 <= inv_of(dend.d1);
			cb_s5 <= dend.cb;
			sb_s5 <= dend.sb;
			ct_s5 <= dend.ct;
			st_s5 <= dend.st;
		end
	end

	// ---- s6, s7: v terms, reciprocal split into high and low partial products ----
	logic signed [IW-1:0] vi [4];
	logic signed [TXW-1:0] vt [4];
	logic signed [IHW-1:0] ih [4];
	logic signed [SH:0] il [4];
	logic signed [PLW-1:0] plf [4];

	always_comb begin
		vi[0] = i0_s5;
		vi[1] = i1_s5;
		vi[2] = i0_s5;
		vi[3] = i1_s5;
		vt[0] = TXW'(ct_s5);
		vt[1] = -TXW'(st_s5);
		vt[2] = TXW'(st_s5);
		vt[3] = TXW'(ct_s5);
		for (int k = 0; k < 4; k++) begin
			ih[k] = $signed(vi[k][IW-1:SH]);
			il[k] = $signed({1'b0, vi[k][SH-1:0]});
			plf[k] = il[k] * vt[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				ph_s6[k] <= ih[k] * vt[k];
				pl_s6[k] <= $signed(plf[k][PLW-1:SH]);
			end
			cb_s6 <= cb_s5;
			sb_s6 <= sb_s5;
		end
	end

	logic signed [PHW-1:0] vsum [4];
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			vsum[k] = ph_s6[k] + PHW'(pl_s6[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				v_s7[k] <= VW'(vsum[k]);
			end
			cb_s7 <= cb_s6;
			sb_s7 <= sb_s6;
		end
	end

	// ---- s8, s9: outputs, out j = v[j]*cb +- v[j^1]*sb, minus on odd j ----
	logic signed [VHW-1:0] vh [4];
	logic signed [SH:0] vl [4];
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			vh[k] = $signed(v_s7[k][VW-1:SH]);
			vl[k] = $signed({1'b0, v_s7[k][SH-1:0]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				pah_s8[j] <= vh[j] * cb_s7;
				pbh_s8[j] <= vh[j ^ 1] * sb_s7;
				pal_s8[j] <= vl[j] * cb_s7;
				pbl_s8[j] <= vl[j ^ 1] * sb_s7;
			end
		end
	end

	logic signed [HIW-1:0] hi [4];
	logic signed [LOW-1:0] lo [4];
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			if (j % 2 == 1) begin
				hi[j] = HIW'(pah_s8[j]) - HIW'(pbh_s8[j]);
				lo[j] = LOW'(pal_s8[j]) - LOW'(pbl_s8[j]);
			end else begin
				hi[j] = HIW'(pah_s8[j]) + HIW'(pbh_s8[j]);
				lo[j] = LOW'(pal_s8[j]) + LOW'(pbl_s8[j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				res_s9[j] <= RESW'(hi[j]) + RESW'($signed(lo[j][LOW-1:SH]));
			end
		end
	end

	// ---- output register with saturation ----
	logic signed [31:0] sat [4];
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			if (res_s9[j] > RESW'(OUT_MAX)) begin
				sat[j] = OUT_MAX;
			end else if (res_s9[j] < RESW'(OUT_MIN)) begin
				sat[j] = OUT_MIN;
			end else begin
				sat[j] = res_s9[j][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= '{p_r0c0: sat[0], p_r0c1: sat[1], p_r1c0: sat[2], p_r1c1: sat[3]};
		end
	end

	// ---- checks ----
	`PI_ASSERT_NEXT(a_hold, !en, $stable(valid_s2) && $stable(valid_s9) && pinv_valid)
	`PI_ASSERT_NEXT(a_zero_inv, en && dend.valid && dend.d0.zero, i0_s5 == '0)
	`PI_ASSERT_IMPL(a_inv_lim, valid_s5, (i1_s5 <= RECIP_LIM) && (i1_s5 >= -RECIP_LIM))

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// testbench for the 2x2 pseudo-inverse pipeline with an in-bench fixed point predictor
`timescale 1ns / 100ps

module tb_top;
	import pinv_pkg::*;

	localparam int STAGES = 16;
	localparam int LATENCY = 2 * STAGES + 51;
	localparam longint PI_Q30 = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint GAIN_Q30 = 64'sd652032874;
	localparam longint INV_LIMIT = 64'sd1099511627776;
	localparam longint ATAN_Q30 [0:31] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
		64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
		64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
		64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
		64'h00000001, 64'h00000000};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic mat_valid = 1'b0;
	logic mat_stall;
	mat_t mat = '0;
	logic pinv_valid;
	logic pinv_stall = 1'b0;
	pinv_t pinv;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;

	mat_t pending_mats[$];
	pinv_t expected_pinv[$];
	logic [15:0] epsilon = 16'd410;
	int gap_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	logic mat_fire = 1'b0;

	pseudo_inverse_2x2 u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.mat_valid(mat_valid),
		.mat_stall(mat_stall),
		.mat(mat),
		.pinv_valid(pinv_valid),
		.pinv_stall(pinv_stall),
		.pinv(pinv),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// magnitude and angle of (x, y)
	function automatic void cordic_vector(input longint x0, input longint y0,
			output longint mag, output longint ang);
		longint x, y, z, dx, dy;
		x = x0;
		y = y0;
		z = 0;
		if (x == 0 && y == 0) begin
			mag = 0;
			ang = 0;
			return;
		end
		if (x < 0) begin
			z = (y >= 0) ? PI_Q30 : -PI_Q30;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += ATAN_Q30[i];
			end else begin
				x -= dx; y += dy; z -= ATAN_Q30[i];
			end
		end
		mag = (x * GAIN_Q30) >>> 30;
		ang = z;
	endfunction

	// cos and sin in q.20
	function automatic void cordic_rotate(input longint z0, output longint c, output longint s);
		longint x, y, z, dx, dy;
		logic flip;
		x = GAIN_Q30;
		y = 0;
		z = z0;
		flip = 1'b0;
		if (z > HALF_PI_Q30) begin
			z -= PI_Q30; flip = 1'b1;
		end else if (z < -HALF_PI_Q30) begin
			z += PI_Q30; flip = 1'b1;
		end
		for (int i = 0; i < STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_Q30[i];
			end else begin
				x += dx; y -= dy; z += ATAN_Q30[i];
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		c = x >>> 10;
		s = y >>> 10;
	endfunction

	function automatic longint singular_inverse(input longint s, input logic [15:0] eps);
		longint thr, m, q;
		thr = longint'(eps) * 32768;
		m = (s < 0) ? -s : s;
		if (s == 0 || m < thr)
			return 0;
		q = (64'sd1 <<< 43) / s;
		if (q > INV_LIMIT) q = INV_LIMIT;
		if (q < -INV_LIMIT) q = -INV_LIMIT;
		return q;
	endfunction

	function automatic logic signed [31:0] sat_q16(input longint acc);
		longint p;
		p = acc >>> 20;
		if (p > 64'sd2147483647) p = 64'sd2147483647;
		if (p < -64'sd2147483648) p = -64'sd2147483648;
		return 32'(p);
	endfunction

	function automatic pinv_t predict_pinv(input mat_t a, input logic [15:0] eps);
		longint m0, m1, m2, m3, e, f, g, h, q, r, ahe, agf;
		longint cb, sb, ct, st, i0, i1, v0, v1, v2, v3;
		pinv_t p;
		m0 = longint'(a.a_r0c0);
		m1 = longint'(a.a_r0c1);
		m2 = longint'(a.a_r1c0);
		m3 = longint'(a.a_r1c1);
		e = (m0 + m3) * 16384;
		f = (m0 - m3) * 16384;
		g = (m1 + m2) * 16384;
		h = (m1 - m2) * 16384;
		cordic_vector(e, h, q, ahe);
		cordic_vector(f, g, r, agf);
		cordic_rotate((ahe - agf) >>> 1, cb, sb);
		cordic_rotate((ahe + agf) >>> 1, ct, st);
		i0 = singular_inverse(q + r, eps);
		i1 = singular_inverse(q - r, eps);
		v0 = (i0 * ct) >>> 20;
		v1 = (i1 * -st) >>> 20;
		v2 = (i0 * st) >>> 20;
		v3 = (i1 * ct) >>> 20;
		p.p_r0c0 = sat_q16(v0 * cb + v1 * sb);
		p.p_r0c1 = sat_q16(v1 * cb - v0 * sb);
		p.p_r1c0 = sat_q16(v2 * cb + v3 * sb);
		p.p_r1c1 = sat_q16(v3 * cb - v2 * sb);
		return p;
	endfunction

	function automatic mat_t make_mat(input logic signed [15:0] a, input logic signed [15:0] b,
			input logic signed [15:0] c, input logic signed [15:0] d);
		mat_t m;
		m.a_r0c0 = a; m.a_r0c1 = b; m.a_r1c0 = c; m.a_r1c1 = d;
		return m;
	endfunction

	function automatic logic signed [15:0] rand_elem(input int span);
		return 16'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic mat_t random_mat();
		int kind;
		int k;
		mat_t m;
		kind = $urandom_range(0, 9);
		if (kind < 4) begin
			m = mat_t'({$urandom, $urandom});
		end else if (kind < 6) begin
			m = make_mat(rand_elem(64), rand_elem(64), rand_elem(64), rand_elem(64));
		end else if (kind < 8) begin
			// second row a multiple of the first, sometimes slightly perturbed: one singular value is zero or near zero
			k = $urandom_range(0, 8) - 4;
			m.a_r0c0 = rand_elem(4096);
			m.a_r0c1 = rand_elem(4096);
			m.a_r1c0 = 16'(longint'(m.a_r0c0) * k);
			m.a_r1c1 = 16'(longint'(m.a_r0c1) * k);
			if ($urandom_range(0, 1)) m.a_r1c1 += rand_elem(2);
		end else begin
			m = make_mat(rand_elem(8192), rand_elem(8192), rand_elem(8192), rand_elem(8192));
		end
		return m;
	endfunction

	always @(posedge clk) begin
		mat_fire <= mat_valid && !mat_stall;
		if (mat_valid && !mat_stall)
			expected_pinv.push_back(predict_pinv(mat, epsilon));
	end

	// sender: new beat only once the last one has moved
	always @(negedge clk) begin
		if (arst_n && (!mat_valid || mat_fire)) begin
			if (pending_mats.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
				mat <= pending_mats.pop_front();
				mat_valid <= 1'b1;
			end else begin
				mat_valid <= 1'b0;
			end
		end
		pinv_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		pinv_t want;
		if (arst_n && pinv_valid && !pinv_stall) begin
			if (expected_pinv.size() == 0) begin
				$error("unexpected result beat %h", pinv);
				errors++;
			end else begin
				want = expected_pinv.pop_front();
				if (pinv.p_r0c0 !== want.p_r0c0) begin
					$error("p_r0c0 expected %0d actual %0d", want.p_r0c0, pinv.p_r0c0);
					errors++;
				end
				if (pinv.p_r0c1 !== want.p_r0c1) begin
					$error("p_r0c1 expected %0d actual %0d", want.p_r0c1, pinv.p_r0c1);
					errors++;
				end
				if (pinv.p_r1c0 !== want.p_r1c0) begin
					$error("p_r1c0 expected %0d actual %0d", want.p_r1c0, pinv.p_r1c0);
					errors++;
				end
				if (pinv.p_r1c1 !== want.p_r1c1) begin
					$error("p_r1c1 expected %0d actual %0d", want.p_r1c1, pinv.p_r1c1);
					errors++;
				end
			end
		end
	end

	task automatic drain();
		while (pending_mats.size() > 0 || mat_valid || expected_pinv.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_epsilon(input logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		epsilon = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [15:0] eps_list [0:4];
		eps_list = '{16'd410, 16'd0, 16'hFFFF, 16'd1, 16'($urandom)};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		pending_mats.push_back(make_mat(0, 0, 0, 0));
		pending_mats.push_back(make_mat(4096, 0, 0, 4096));
		pending_mats.push_back(make_mat(32767, 32767, 32767, 32767));
		pending_mats.push_back(make_mat(-32768, -32768, -32768, -32768));
		pending_mats.push_back(make_mat(32767, -32768, -32768, 32767));
		pending_mats.push_back(make_mat(-32768, 32767, 32767, -32768));
		pending_mats.push_back(make_mat(-4096, 0, 0, -4096));
		pending_mats.push_back(make_mat(0, 4096, -4096, 0));
		pending_mats.push_back(make_mat(0, -4096, 4096, 0));
		pending_mats.push_back(make_mat(-4096, 100, 200, 3000));
		pending_mats.push_back(make_mat(4096, 8192, 2048, 4096));
		pending_mats.push_back(make_mat(1, 0, 0, 1));
		pending_mats.push_back(make_mat(0, 0, 0, 1));
		pending_mats.push_back(make_mat(410, 0, 0, 409));
		pending_mats.push_back(make_mat(500, 0, 0, -500));
		pending_mats.push_back(make_mat(-1, -1, -1, -1));
		pending_mats.push_back(make_mat(-3000, -20000, 20000, -3000));

		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0) write_epsilon(eps_list[ph]);
			for (int mode = 0; mode < 3; mode++) begin
				gap_pct = (mode == 0) ? 15 : (mode == 1) ? 88 : 0;
				stall_pct = (mode == 0) ? 88 : (mode == 1) ? 15 : 0;
				for (int n = 0; n < 128; n++)
					pending_mats.push_back(random_mat());
				drain();
			end
		end

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#5ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
